// ===== rtl/sas_pkg.sv =====
package sas_pkg;

  // Default store depth: samples held per run
  localparam int RunDepthDef = 64;

  // Field widths
  localparam int SampleW = 16;
  localparam int SquareW = 31;

  // Controller states
  typedef enum logic [2:0] {
    S_LOAD,
    S_MRD,
    S_MSQ,
    S_MWR,
    S_ERD,
    S_ELD,
    S_EOUT
  } sas_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // accepted input transaction
    logic last;     // accepted transaction ends the run
    logic mrg_rd;   // read samples at both pointers
    logic mrg_sq;   // square the read samples
    logic mrg_wr;   // compare, write larger square, move pointer
    logic emt_rd;   // read square store at emit index
    logic emt_ld;   // load output registers
    logic emt_adv;  // advance emit index
    logic clear;    // end of run: clear count and drop flag
  } sas_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic slot_one;  // current merge write fills the front slot
    logic emt_last;  // current emit index is the last square
  } sas_status_t;

endpackage

// ===== rtl/sas_ctrl.sv =====
module sas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                end_of_run_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  sas_pkg::sas_status_t status_i,
  output sas_pkg::sas_cmd_t    cmd_o
);
  import sas_pkg::*;

  sas_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i && end_of_run_i) state_d = S_MRD;
      end
      S_MRD:  state_d = S_MSQ;
      S_MSQ:  state_d = S_MWR;
      S_MWR: begin
        state_d = status_i.slot_one ? S_ERD : S_MRD;
      end
      S_ERD:  state_d = S_ELD;
      S_ELD:  state_d = S_EOUT;
      S_EOUT: begin
        if (out_ready_i) state_d = status_i.emt_last ? S_LOAD : S_ERD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cmd_o.last = in_valid_i && end_of_run_i;
      end
      S_MRD: cmd_o.mrg_rd = 1'b1;
      S_MSQ: cmd_o.mrg_sq = 1'b1;
      S_MWR: cmd_o.mrg_wr = 1'b1;
      S_ERD: cmd_o.emt_rd = 1'b1;
      S_ELD: cmd_o.emt_ld = 1'b1;
      S_EOUT: begin
        out_valid_o   = 1'b1;
        cmd_o.emt_adv = out_ready_i && !status_i.emt_last;
        cmd_o.clear   = out_ready_i && status_i.emt_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Input and output sides are never open together
  a_in_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is offered");

  // A merge write always leads to another read or to emission
  a_mwr_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MWR) |=> (state_q == S_MRD || state_q == S_ERD))
    else $error("merge write left the merge walk");

  // A held result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result withdrawn before it was taken");

endmodule

// ===== rtl/sas_dpath.sv =====
module sas_dpath #(
  parameter int RUN_DEPTH = sas_pkg::RunDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [sas_pkg::SampleW-1:0] sample_i,
  input  sas_pkg::sas_cmd_t            cmd_i,
  output sas_pkg::sas_status_t         status_o,
  output logic [sas_pkg::SquareW-1:0]  square_o,
  output logic                         final_result_o,
  output logic                         overflowed_o
);
  import sas_pkg::*;

  localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 1);

  // Stores
  logic signed [SampleW-1:0] smp_mem [RUN_DEPTH];
  logic [SquareW-1:0]        sq_mem  [RUN_DEPTH];

  // Control registers
  logic [CW-1:0] cnt_q;
  logic          drop_q;
  logic [AW-1:0] left_q, right_q;
  logic [CW-1:0] slot_q;
  logic [CW-1:0] k_q;

  // Payload registers
  logic signed [SampleW-1:0] rd_l_q, rd_r_q;
  logic [SquareW-1:0]        sq_l_q, sq_r_q;
  logic [SquareW-1:0]        sq_rd_q;
  logic [SquareW-1:0]        square_q;
  logic                      final_q, ovf_q;

  logic          full;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] slot_m1;
  logic [CW-1:0] k_p1;
  logic signed [2*SampleW-1:0] prod_l, prod_r;
  logic          take_left;
  logic [SquareW-1:0] wr_sq;

  assign full      = (cnt_q == CW'(RUN_DEPTH));
  assign cnt_next  = full ? cnt_q : CW'(cnt_q + CW'(1));
  assign last_idx  = CW'(cnt_next - CW'(1));
  assign slot_m1   = CW'(slot_q - CW'(1));
  assign k_p1      = CW'(k_q + CW'(1));
  assign prod_l    = rd_l_q * rd_l_q;
  assign prod_r    = rd_r_q * rd_r_q;
  assign take_left = (sq_l_q > sq_r_q);
  assign wr_sq     = take_left ? sq_l_q : sq_r_q;

  assign status_o.slot_one = (slot_q == CW'(1));
  assign status_o.emt_last = (k_p1 == cnt_q);

  // Sample store: write during load, read both pointers during merge
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) smp_mem[cnt_q[AW-1:0]] <= sample_i;
    if (cmd_i.mrg_rd) begin
      rd_l_q <= smp_mem[left_q];
      rd_r_q <= smp_mem[right_q];
    end
  end

  // Square store: write from the back during merge, read in emit order
  always_ff @(posedge clk_i) begin
    if (cmd_i.mrg_wr) sq_mem[slot_m1[AW-1:0]] <= wr_sq;
    if (cmd_i.emt_rd) sq_rd_q <= sq_mem[k_q[AW-1:0]];
  end

  // Square both read samples; the value fits in 31 bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.mrg_sq) begin
      sq_l_q <= prod_l[SquareW-1:0];
      sq_r_q <= prod_r[SquareW-1:0];
    end
  end

  // Load output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.emt_ld) begin
      square_q <= sq_rd_q;
      final_q  <= status_o.emt_last;
      ovf_q    <= drop_q;
    end
  end

  // Run count, drop flag, pointers and emit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      left_q  <= '0;
      right_q <= '0;
      slot_q  <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= cnt_next;
        if (full) drop_q <= 1'b1;
        if (cmd_i.last) begin
          left_q  <= '0;
          right_q <= last_idx[AW-1:0];
          slot_q  <= cnt_next;
          k_q     <= '0;
        end
      end
      if (cmd_i.mrg_wr) begin
        slot_q <= slot_m1;
        if (take_left) begin
          left_q <= AW'(left_q + AW'(1));
        end else if (right_q != '0) begin
          right_q <= AW'(right_q - AW'(1));
        end
      end
      if (cmd_i.emt_adv) k_q <= k_p1;
      if (cmd_i.clear) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end
    end
  end

  assign square_o       = square_q;
  assign final_result_o = final_q;
  assign overflowed_o   = ovf_q;

  // Pointers never cross while a merge step reads
  a_ptr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mrg_rd |-> (left_q <= right_q))
    else $error("merge pointers crossed");

  // A merge write always has a free slot
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mrg_wr |-> (slot_q != '0))
    else $error("merge write with no slot left");

  // Emission reads only squares of the current run
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emt_rd |-> (k_q < cnt_q))
    else $error("emit index beyond run length");

endmodule

// ===== rtl/sorted_array_squares.sv =====
// Sorted squares, two-pointer merge. Samples of a run enter one per cycle
// (in_ready_o is high while loading) until a transaction with end_of_run_i
// set; samples beyond RUN_DEPTH are dropped and the run's results carry
// overflowed_o. The last sample starts a merge walk that, for each stored
// sample, reads both pointers from the sample store, squares them, then
// compares and writes the larger square into the square store from the
// back. The squares are then offered in ascending order, each read from
// the square store, loaded into the output registers and held until taken;
// the final one carries final_result_o. No new samples are taken until the
// final square is taken.
module sorted_array_squares #(
  parameter int RUN_DEPTH = sas_pkg::RunDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sas_pkg::SampleW-1:0] sample_i,
  input  logic                               end_of_run_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sas_pkg::SquareW-1:0]        square_o,
  output logic                               final_result_o,
  output logic                               overflowed_o
);
  import sas_pkg::*;

  sas_cmd_t    cmd;
  sas_status_t status;

  sas_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .end_of_run_i (end_of_run_i),
    .in_ready_o   (in_ready_o),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  sas_dpath #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .square_o       (square_o),
    .final_result_o (final_result_o),
    .overflowed_o   (overflowed_o)
  );

endmodule
